// ----- rtl/hslr_pkg.sv -----
package hslr_pkg;

    // Default fraction width of the internal lightness and saturation values.
    localparam int FRAC_BITS_DEF = 12;

    // Fraction width of the values held in the configuration registers.
    localparam int CFG_FRAC = 12;

    // Register indexes of the configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_HUE        = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_SATURATION = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LIGHTNESS_OFFSET  = 2'd2;

    localparam int HUE_W = 9;
    localparam int SAT_W = 13;
    localparam int OFF_W = 14;

    // Hue angles in degrees.
    localparam logic [HUE_W-1:0] DEG_60  = 9'd60;
    localparam logic [HUE_W-1:0] DEG_120 = 9'd120;
    localparam logic [HUE_W-1:0] DEG_180 = 9'd180;
    localparam logic [HUE_W-1:0] DEG_240 = 9'd240;
    localparam logic [HUE_W:0]   DEG_360 = 10'd360;

    // Width of a hue weight, which runs from 0 to 60.
    localparam int WT_W = 6;
    localparam logic [WT_W-1:0] WT_FULL = 6'd60;

    // (max + min) * 2^F / 510 is taken as (sum * RECIP_255) >> (33 - F),
    // which is exact for every sum up to 510 and F up to 16.
    localparam int SUM_W = 9;
    localparam int RECIP_W = 25;
    localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;
    localparam int RECIP_SHIFT = 33;
    localparam int PROD_W = SUM_W + RECIP_W;

    localparam int NUM_STAGES = 7;
    localparam int LIGHT_STAGES = 3;
    localparam int COLOR_STAGES = NUM_STAGES - LIGHT_STAGES;

    typedef struct packed {
        logic       recolor;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // Per-channel weight of (v2 - v1), in sixtieths.
    typedef struct packed {
        logic [WT_W-1:0] blue;
        logic [WT_W-1:0] green;
        logic [WT_W-1:0] red;
    } hue_wt_t;

    function automatic logic [WT_W-1:0] hue_weight(input logic [HUE_W-1:0] d);
        logic [HUE_W-1:0] down;
        begin
            down = DEG_240 - d;
            if (d < DEG_60)
                hue_weight = d[WT_W-1:0];
            else if (d < DEG_180)
                hue_weight = WT_FULL;
            else if (d < DEG_240)
                hue_weight = down[WT_W-1:0];
            else
                hue_weight = '0;
        end
    endfunction

    // Adds an offset to an angle below 360 and wraps it back below 360.
    function automatic logic [HUE_W-1:0] hue_add(input logic [HUE_W-1:0] h,
                                                 input logic [HUE_W-1:0] a);
        logic [HUE_W:0] s;
        logic [HUE_W:0] w;
        begin
            s = {1'b0, h} + {1'b0, a};
            w = (s >= DEG_360) ? s - DEG_360 : s;
            hue_add = w[HUE_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/hslr_cfg.sv -----
module hslr_cfg
    import hslr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output hue_wt_t                hue_wt,
    output logic [FRAC_BITS:0]     sat,
    output logic signed [FRAC_BITS+1:0] offset
);

    localparam int LW = FRAC_BITS + 1;
    localparam int LSH = (FRAC_BITS >= CFG_FRAC) ? FRAC_BITS - CFG_FRAC : 0;
    localparam int RSH = (FRAC_BITS < CFG_FRAC) ? CFG_FRAC - FRAC_BITS : 0;
    localparam logic [LW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [SAT_W-1:0] sat_reg, sat_next;
    logic [OFF_W-1:0] off_reg, off_next;

    logic [HUE_W:0]   hue_less;
    logic [HUE_W-1:0] hue_wrap;
    logic signed [FRAC_BITS+15:0] off_wide;
    logic signed [FRAC_BITS+15:0] off_shift;
    logic [FRAC_BITS+12:0] sat_wide;
    logic [FRAC_BITS+12:0] sat_shift;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        hue_next = hue_reg;
        sat_next = sat_reg;
        off_next = off_reg;
        if (cfg_valid)
        begin
            unique case (cfg_addr)
                REG_TARGET_HUE:        hue_next = cfg_data[HUE_W-1:0];
                REG_TARGET_SATURATION: sat_next = cfg_data[SAT_W-1:0];
                REG_LIGHTNESS_OFFSET:  off_next = cfg_data[OFF_W-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_reg <= '0;
            sat_reg <= '0;
            off_reg <= '0;
        end
        else
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            off_reg <= off_next;
        end
    end

    // Hue values from 360 up to 511 wrap once.
    assign hue_less = {1'b0, hue_reg} - DEG_360;
    assign hue_wrap = ({1'b0, hue_reg} >= DEG_360) ? hue_less[HUE_W-1:0] : hue_reg;

    always_comb
    begin
        hue_wt.red   = hue_weight(hue_add(hue_wrap, DEG_120));
        hue_wt.green = hue_weight(hue_wrap);
        hue_wt.blue  = hue_weight(hue_add(hue_wrap, DEG_240));
    end

    // Rescale Q1.12 saturation and signed Q2.12 offset to FRAC_BITS.
    always_comb
    begin
        off_wide  = {{(FRAC_BITS+2){off_reg[OFF_W-1]}}, off_reg};
        off_shift = (off_wide <<< LSH) >>> RSH;
        offset    = off_shift[FRAC_BITS+1:0];

        sat_wide  = {{FRAC_BITS{1'b0}}, sat_reg};
        sat_shift = (sat_wide << LSH) >> RSH;
        if (sat_shift > {{(SAT_W-1){1'b0}}, ONE})
            sat = ONE;
        else
            sat = sat_shift[LW-1:0];
    end

endmodule

// ----- rtl/hslr_pipe_ctrl.sv -----
module hslr_pipe_ctrl
    import hslr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [NUM_STAGES-1:0] adv
);

    logic [NUM_STAGES-1:0] valid_reg, valid_next;

    // A stage loads when it is empty or when the stage after it loads too,
    // so bubbles close up while the output is stalled.
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = (adv & {valid_reg[NUM_STAGES-2:0], in_valid}) | (~adv & valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NUM_STAGES-1] && !out_ready |=> valid_reg[NUM_STAGES-1])
        else $error("finished item dropped while the output was stalled");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ready |-> !in_ready)
        else $error("input taken while every stage holds an item");

    a_first_moves: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && adv[1] |=> valid_reg[1])
        else $error("item lost between the first two stages");

endmodule

// ----- rtl/hslr_light.sv -----
module hslr_light
    import hslr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic [LIGHT_STAGES-1:0]      adv,
    input  pix_t                         pix_in,
    input  logic signed [FRAC_BITS+1:0]  offset,
    output pix_t                         pix_out,
    output logic [FRAC_BITS:0]           light
);

    localparam int LW = FRAC_BITS + 1;
    localparam logic [LW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    pix_t             pix1_reg, pix2_reg, pix3_reg;
    logic [SUM_W-1:0] sum1_reg, sum1_next;
    logic [LW-1:0]    lraw2_reg, lraw2_next;
    logic [LW-1:0]    l3_reg, l3_next;

    logic [7:0]          mx, mn;
    logic [PROD_W-1:0]   prod;
    logic signed [LW+1:0] lsum;

    // Stage one: brightest plus darkest channel.
    always_comb
    begin
        mx = (pix_in.red > pix_in.green) ? pix_in.red : pix_in.green;
        mx = (mx > pix_in.blue) ? mx : pix_in.blue;
        mn = (pix_in.red < pix_in.green) ? pix_in.red : pix_in.green;
        mn = (mn < pix_in.blue) ? mn : pix_in.blue;
        sum1_next = {1'b0, mx} + {1'b0, mn};
    end

    // Stage two: divide by 510 through the reciprocal.
    always_comb
    begin
        prod = {{RECIP_W{1'b0}}, sum1_reg} * {{SUM_W{1'b0}}, RECIP_255};
        lraw2_next = prod[RECIP_SHIFT-FRAC_BITS +: LW];
    end

    // Stage three: add the offset and clamp to zero..one.
    always_comb
    begin
        lsum = $signed({2'b00, lraw2_reg}) + $signed({offset[FRAC_BITS+1], offset});
        if (lsum[LW+1])
            l3_next = '0;
        else if (lsum[LW:0] > {1'b0, ONE})
            l3_next = ONE;
        else
            l3_next = lsum[LW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pix1_reg <= pix_in;
            sum1_reg <= sum1_next;
        end
        if (adv[1])
        begin
            pix2_reg  <= pix1_reg;
            lraw2_reg <= lraw2_next;
        end
        if (adv[2])
        begin
            pix3_reg <= pix2_reg;
            l3_reg   <= l3_next;
        end
    end

    assign pix_out = pix3_reg;
    assign light   = l3_reg;

endmodule

// ----- rtl/hslr_color.sv -----
module hslr_color
    import hslr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    clk,
    input  logic [COLOR_STAGES-1:0] adv,
    input  pix_t                    pix_in,
    input  logic [FRAC_BITS:0]      light,
    input  logic [FRAC_BITS:0]      sat,
    input  hue_wt_t                 hue_wt,
    output logic [7:0]              red,
    output logic [7:0]              green,
    output logic [7:0]              blue,
    output logic [7:0]              alpha
);

    localparam int LW = FRAC_BITS + 1;
    localparam int XW = FRAC_BITS + 6;

    pix_t pix4_reg, pix5_reg, pix6_reg;

    logic [LW-1:0]   l4_reg;
    logic [LW-1:0]   ph4_reg, ph4_next;
    logic [LW-1:0]   v1_5_reg, v1_5_next;
    logic [LW-1:0]   dv5_reg, dv5_next;
    logic [7:0]      gray5_reg, gray5_next;
    logic [7:0]      gray6_reg;
    logic [XW-1:0]   x6_reg [3];
    logic [XW-1:0]   x6_next [3];
    logic [7:0]      rgb7_reg [3];
    logic [7:0]      rgb7_next [3];
    logic [7:0]      alpha7_reg;

    logic [2*LW-1:0] p;
    logic [LW:0]     v2t;
    logic [LW-1:0]   v2;
    logic [LW:0]     v1t;
    logic [LW+7:0]   g;
    logic [WT_W-1:0] wt [3];
    logic [XW:0]     base60;
    logic [XW:0]     mw [3];
    logic [XW:0]     xs [3];
    logic [XW+3:0]   y [3];
    logic [7:0]      c [3];

    // Stage four: lightness times saturation.
    always_comb
    begin
        p = {{LW{1'b0}}, light} * {{LW{1'b0}}, sat};
        ph4_next = p[FRAC_BITS +: LW];
    end

    // Stage five: the two HSL helper values and the gray level.
    always_comb
    begin
        if (l4_reg[FRAC_BITS:FRAC_BITS-1] == 2'b00)
            v2t = {1'b0, l4_reg} + {1'b0, ph4_reg};
        else
            v2t = {1'b0, l4_reg} + {1'b0, sat} - {1'b0, ph4_reg};
        v2 = v2t[LW-1:0];
        v1t = {l4_reg, 1'b0} - {1'b0, v2};
        v1_5_next = v1t[LW-1:0];
        dv5_next = v2 - v1t[LW-1:0];
        g = {l4_reg, 8'b0} - {8'b0, l4_reg};
        gray5_next = g[FRAC_BITS +: 8];
    end

    // Stage six: each channel in sixtieths, 60*v1 + (v2 - v1)*weight.
    always_comb
    begin
        wt[0] = hue_wt.red;
        wt[1] = hue_wt.green;
        wt[2] = hue_wt.blue;
        base60 = {v1_5_reg, 6'b0} - {4'b0, v1_5_reg, 2'b0};
        for (int i = 0; i < 3; i++)
        begin
            mw[i] = {6'b0, dv5_reg} * {{(LW){1'b0}}, wt[i]};
            xs[i] = base60 + mw[i];
            x6_next[i] = xs[i][XW-1:0];
        end
    end

    // Stage seven: 255 / (60 * ONE) equals 17 / (4 * ONE).
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            y[i] = {x6_reg[i], 4'b0} + {4'b0, x6_reg[i]};
            c[i] = y[i][FRAC_BITS+2 +: 8];
            if (!pix6_reg.recolor)
                rgb7_next[i] = '0;
            else if (sat == '0)
                rgb7_next[i] = gray6_reg;
            else
                rgb7_next[i] = c[i];
        end
        if (!pix6_reg.recolor)
        begin
            rgb7_next[0] = pix6_reg.red;
            rgb7_next[1] = pix6_reg.green;
            rgb7_next[2] = pix6_reg.blue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pix4_reg <= pix_in;
            l4_reg   <= light;
            ph4_reg  <= ph4_next;
        end
        if (adv[1])
        begin
            pix5_reg  <= pix4_reg;
            v1_5_reg  <= v1_5_next;
            dv5_reg   <= dv5_next;
            gray5_reg <= gray5_next;
        end
        if (adv[2])
        begin
            pix6_reg  <= pix5_reg;
            gray6_reg <= gray5_reg;
            for (int i = 0; i < 3; i++)
                x6_reg[i] <= x6_next[i];
        end
        if (adv[3])
        begin
            alpha7_reg <= pix6_reg.alpha;
            for (int i = 0; i < 3; i++)
                rgb7_reg[i] <= rgb7_next[i];
        end
    end

    assign red   = rgb7_reg[0];
    assign green = rgb7_reg[1];
    assign blue  = rgb7_reg[2];
    assign alpha = alpha7_reg;

endmodule

// ----- rtl/masked_hsl_pixel_recolor_core.sv -----
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: red, green, blue, alpha, mask
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: red, green, blue, alpha
// cfg       in         cfg_valid/cfg_ready          cfg_addr (register), cfg_data
//
// One item per cycle is accepted and delivered while the output is not stalled; an item
// passes seven register stages, from the stage-one register to the output register.
// Reset clears the stage valid bits and the three configuration registers.
// A stalled output holds its item; ready ripples back stage by stage, so empty
// stages keep filling and input is refused only when every stage holds an item.
module masked_hsl_pixel_recolor_core
    import hslr_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,  // base_red, base_green, base_blue, base_alpha, mask_red
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [NUM_STAGES-1:0]       adv;
    hue_wt_t                     hue_wt;
    logic [FRAC_BITS:0]          sat;
    logic signed [FRAC_BITS+1:0] offset;
    pix_t                        pix_in;
    pix_t                        pix_mid;
    logic [FRAC_BITS:0]          light;
    logic [7:0]                  red, green, blue, alpha;

    always_comb
    begin
        pix_in.red     = s_axis_tdata[7:0];
        pix_in.green   = s_axis_tdata[15:8];
        pix_in.blue    = s_axis_tdata[23:16];
        pix_in.alpha   = s_axis_tdata[31:24];
        pix_in.recolor = (s_axis_tdata[39:32] != 8'd0);
    end

    hslr_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .hue_wt    (hue_wt),
        .sat       (sat),
        .offset    (offset)
    );

    hslr_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .adv       (adv)
    );

    hslr_light #(
        .FRAC_BITS (FRAC_BITS)
    ) u_light (
        .clk     (clk),
        .adv     (adv[LIGHT_STAGES-1:0]),
        .pix_in  (pix_in),
        .offset  (offset),
        .pix_out (pix_mid),
        .light   (light)
    );

    hslr_color #(
        .FRAC_BITS (FRAC_BITS)
    ) u_color (
        .clk    (clk),
        .adv    (adv[NUM_STAGES-1:LIGHT_STAGES]),
        .pix_in (pix_mid),
        .light  (light),
        .sat    (sat),
        .hue_wt (hue_wt),
        .red    (red),
        .green  (green),
        .blue   (blue),
        .alpha  (alpha)
    );

    assign m_axis_tdata = {alpha, blue, green, red};

endmodule

// ----- dv/masked_hsl_pixel_recolor_core_tb.sv -----
`timescale 1ns / 1ps

module masked_hsl_pixel_recolor_core_tb;
    import hslr_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 92;
    localparam int HOLD_OFF_CYCLES = 120;
    // No register sits at this index, so a write there must change nothing.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    class recolor_scoreboard;
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [OFF_W-1:0] offset;
        logic [31:0] expected_pixels[$];
        string channel_names[4] = '{"red", "green", "blue", "alpha"};
        int errors;

        function new();
            hue = '0;
            sat = '0;
            offset = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_TARGET_HUE:        hue = data[HUE_W-1:0];
                REG_TARGET_SATURATION: sat = data[SAT_W-1:0];
                REG_LIGHTNESS_OFFSET:  offset = data[OFF_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] channel_level(longint v1, longint v2, longint d);
            longint x60;
            longint c;
            if (d < 60)
                x60 = 60 * v1 + (v2 - v1) * d;
            else if (d < 180)
                x60 = 60 * v2;
            else if (d < 240)
                x60 = 60 * v1 + (v2 - v1) * (240 - d);
            else
                x60 = 60 * v1;
            if (x60 < 0)
                x60 = 0;
            c = (255 * x60) / (60 * (longint'(1) << FRAC));
            if (c > 255)
                c = 255;
            return c[7:0];
        endfunction

        function logic [31:0] recolor_pixel(logic [39:0] px);
            longint one;
            longint r;
            longint g;
            longint b;
            longint mx;
            longint mn;
            longint lum;
            longint off;
            longint s;
            longint v1;
            longint v2;
            longint h;
            longint grey;
            logic [7:0] alpha;
            logic [7:0] cr;
            logic [7:0] cg;
            logic [7:0] cb;
            one = longint'(1) << FRAC;
            r = px[7:0];
            g = px[15:8];
            b = px[23:16];
            alpha = px[31:24];
            if (px[39:32] == 8'd0)
                return px[31:0];
            mx = (r > g) ? r : g;
            mx = (mx > b) ? mx : b;
            mn = (r < g) ? r : g;
            mn = (mn < b) ? mn : b;
            lum = ((mx + mn) * one) / 510;
            // The offset is biased positive before the rescale so that it floors correctly.
            off = longint'($signed(offset));
            off = (((off + 8192) << FRAC) >> 12) - (longint'(2) << FRAC);
            lum = lum + off;
            if (lum < 0)
                lum = 0;
            if (lum > one)
                lum = one;
            s = (longint'(sat) << FRAC) >> 12;
            if (s > one)
                s = one;
            if (s == 0)
            begin
                grey = (255 * lum) >> FRAC;
                if (grey > 255)
                    grey = 255;
                return {alpha, grey[7:0], grey[7:0], grey[7:0]};
            end
            if (2 * lum < one)
                v2 = (lum * (one + s)) >> FRAC;
            else
                v2 = lum + s - ((lum * s) >> FRAC);
            v1 = 2 * lum - v2;
            h = longint'(hue) % 360;
            cr = channel_level(v1, v2, (h + 120) % 360);
            cg = channel_level(v1, v2, h);
            cb = channel_level(v1, v2, (h + 240) % 360);
            return {alpha, cb, cg, cr};
        endfunction

        function void note_pixel(logic [39:0] px);
            expected_pixels.push_back(recolor_pixel(px));
        endfunction

        function void check_pixel(logic [31:0] got);
            logic [31:0] want;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: pixel %h arrived with none expected", $time, got);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            for (int i = 0; i < 4; i++)
            begin
                if (got[8*i +: 8] != want[8*i +: 8])
                begin
                    $display("%0t: %s expected %0d actual %0d", $time, channel_names[i],
                             want[8*i +: 8], got[8*i +: 8]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;  // base_red, base_green, base_blue, base_alpha, mask_red
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [31:0]           m_axis_tdata;  // out_red, out_green, out_blue, out_alpha
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    recolor_scoreboard sb;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_cycles;
    int src_modes[4] = '{0, 53, 0, 11};
    int snk_modes[4] = '{0, 0, 53, 11};

    masked_hsl_pixel_recolor_core #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_addr, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_pixel(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata);
        end
    end

    // Output side: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Valid is left high after an item so back-to-back items never toggle it.
    task automatic send_pixel(input logic [39:0] px);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 2) @(posedge clk);
    endtask

    task automatic program_regs(input int hue_v, input int sat_v, input int off_v,
                                input bit poke_unused);
        logic [CFG_ADDR_W-1:0] addrs[4];
        logic [CFG_DATA_W-1:0] words[4];
        int count;
        wait_drained();
        addrs = '{REG_TARGET_HUE, REG_TARGET_SATURATION, REG_LIGHTNESS_OFFSET, REG_UNUSED};
        words = '{hue_v[CFG_DATA_W-1:0], sat_v[CFG_DATA_W-1:0], off_v[CFG_DATA_W-1:0],
                  CFG_DATA_W'($urandom)};
        count = poke_unused ? 4 : 3;
        for (int i = 0; i < count; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_addr <= addrs[i];
            cfg_data <= words[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_word(int lo, int mid, int hi, int rmin, int rmax);
        case ($urandom_range(5))
            0: return lo;
            1: return mid;
            2: return hi;
            3: return rmin;
            4: return rmax;
            default: return rmin + int'($urandom_range(rmax - rmin));
        endcase
    endfunction

    function automatic logic [39:0] random_pixel();
        logic [7:0] ch[3];
        logic [7:0] mask;
        for (int i = 0; i < 3; i++)
            ch[i] = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                             : 8'($urandom_range(255));
        mask = ($urandom_range(6) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        return {mask, 8'($urandom), ch[2], ch[1], ch[0]};
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        hold_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at reset give zero saturation, so masked pixels come out gray.
        send_pixel({8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        send_pixel({8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        send_pixel({8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF});
        send_pixel({8'h01, 8'hFF, 8'h00, 8'h00, 8'h00});
        send_pixel({8'h80, 8'h5A, 8'h10, 8'hC8, 8'h37});

        program_regs(0, 4096, 0, 1'b1);
        send_pixel({8'h01, 8'h11, 8'h00, 8'h00, 8'hFF});
        send_pixel({8'h02, 8'h22, 8'h00, 8'hFF, 8'h00});
        send_pixel({8'h04, 8'h33, 8'hFF, 8'h00, 8'h00});
        send_pixel({8'h08, 8'h44, 8'h80, 8'h40, 8'h20});
        send_pixel({8'h10, 8'h55, 8'hFF, 8'hFF, 8'hFF});
        send_pixel({8'h20, 8'h66, 8'h00, 8'h00, 8'h00});

        // Hue that wraps, saturation above one and an offset past one.
        program_regs(511, 8191, 8191, 1'b0);
        send_pixel({8'h40, 8'h77, 8'h30, 8'h20, 8'h10});
        send_pixel({8'h7F, 8'h88, 8'h32, 8'h64, 8'hC8});

        program_regs(360, 2048, -8192, 1'b0);
        send_pixel({8'hAA, 8'h99, 8'hFF, 8'hFF, 8'hFF});
        send_pixel({8'h55, 8'hAA, 8'hC8, 8'h96, 8'h64});

        program_regs(359, 1, -4096, 1'b0);
        send_pixel({8'hFE, 8'hBB, 8'h00, 8'h80, 8'hFF});
        send_pixel({8'hC3, 8'hCC, 8'h7F, 8'h7F, 8'h7F});

        program_regs(239, 4096, 4096, 1'b0);
        send_pixel({8'h3C, 8'hDD, 8'h00, 8'h00, 8'h00});
        send_pixel({8'h0F, 8'hEE, 8'h99, 8'h66, 8'h33});

        program_regs(60, 4095, 2048, 1'b0);
        send_pixel({8'hF0, 8'hFF, 8'h00, 8'hFF, 8'hFF});
        send_pixel({8'h99, 8'h01, 8'h03, 8'h02, 8'h01});

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_regs(pick_word(0, 359, 360, 0, 511),
                         pick_word(1, 4096, 4097, 0, 8191),
                         pick_word(-4096, 0, 4096, -8192, 8191),
                         ($urandom_range(3) == 0));
            src_idle_pct = src_modes[p % 4];
            snk_stall_pct = snk_modes[p % 4];
            // With the sender never idle, a long hold-off fills the pipeline.
            if (p == 4)
                hold_cycles = HOLD_OFF_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_pixel(random_pixel());
        end

        wait_drained();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
